@@ rtl/core/lcdbi_pkg.sv @@
`timescale 1ns / 1ps

package lcdbi_pkg;

   // Default geometry of the display RAM
   localparam int DEF_RAM_COLUMNS = 132;
   localparam int DEF_RAM_PAGES   = 9;

   // Linear RAM index width: covers 16 pages of 255 columns
   localparam int IDX_W = 12;

   // Status byte
   localparam logic [7:0] STATUS_BASE = 8'h40;
   localparam logic [7:0] STATUS_ON   = 8'h20;

   // Contrast levels
   localparam logic [5:0] CONTRAST_RESET = 6'h20;
   localparam logic [5:0] CONTRAST_MAX   = 6'h3F;

   // Pages from this one up keep only bit 0 on read
   localparam logic [3:0] PAGE_BIT0_ONLY = 4'd8;

   // Command ranges
   localparam logic [7:0] CMD_COL_LO_MAX = 8'h0F;
   localparam logic [7:0] CMD_COL_HI_MAX = 8'h1F;
   localparam logic [7:0] CMD_LINE_MIN   = 8'h40;
   localparam logic [7:0] CMD_LINE_MAX   = 8'h7F;
   localparam logic [7:0] CMD_PAGE_MIN   = 8'hB0;
   localparam logic [7:0] CMD_PAGE_MAX   = 8'hB8;
   localparam logic [7:0] CMD_ROWN_MIN   = 8'hC0;
   localparam logic [7:0] CMD_ROWN_MAX   = 8'hC7;
   localparam logic [7:0] CMD_ROWR_MIN   = 8'hC8;
   localparam logic [7:0] CMD_ROWR_MAX   = 8'hCF;

   // Single commands
   localparam logic [7:0] CMD_CONTRAST     = 8'h81;
   localparam logic [7:0] CMD_COL_NORMAL   = 8'hA0;
   localparam logic [7:0] CMD_COL_REVERSE  = 8'hA1;
   localparam logic [7:0] CMD_LEVEL_NORMAL = 8'hA2;
   localparam logic [7:0] CMD_LEVEL_MAX    = 8'hA3;
   localparam logic [7:0] CMD_ALLON_OFF    = 8'hA4;
   localparam logic [7:0] CMD_ALLON_ON     = 8'hA5;
   localparam logic [7:0] CMD_INVERT_OFF   = 8'hA6;
   localparam logic [7:0] CMD_INVERT_ON    = 8'hA7;
   localparam logic [7:0] CMD_DISPLAY_OFF  = 8'hAE;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'hAF;
   localparam logic [7:0] CMD_RMW_START    = 8'hE0;
   localparam logic [7:0] CMD_SOFT_RESET   = 8'hE2;
   localparam logic [7:0] CMD_RMW_END      = 8'hEE;

   // One access on the display RAM port
   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       wdata;
   } dram_req_type;

   // Grey levels derived from contrast
   typedef struct packed {
      logic [7:0] high;
      logic [7:0] low;
   } levels_type;

   // Result transfer, read_data in the lowest bits
   typedef struct packed {
      logic [4:0] pad;
      logic       pixels_forced_on;
      logic       pixels_inverted;
      logic       columns_flipped;
      logic       rows_flipped;
      logic [5:0] first_row;
      logic       display_enabled;
      logic [7:0] max_intensity;
      logic [7:0] min_intensity;
      logic [7:0] read_data;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

   // Contrast level to grey levels
   function automatic levels_type map_contrast(input logic [5:0] lvl);
      levels_type r;
      logic [7:0] l;
      l = {3'b000, lvl[4:0]};
      if (!lvl[5]) begin
         r.low  = (l + 8'd1) >> 1;
         r.high = 8'h0F + l * 8'd7;
      end else begin
         r.low  = 8'h17 + l * 8'd7;
         r.high = 8'hEF + ((l + 8'd1) >> 1);
      end
      return r;
   endfunction

endpackage

@@ rtl/core/lcdbi_dram.sv @@
`timescale 1ns / 1ps

// Display RAM: one port, read data registered, zero sweep after reset
module lcdbi_dram
   import lcdbi_pkg::*;
#(
   parameter int DEPTH  = DEF_RAM_COLUMNS * DEF_RAM_PAGES,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic         clock,
   input  logic         reset,
   input  dram_req_type req,
   output logic [7:0]   rd_data,
   output logic         clear_busy
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [7:0]        mem [DEPTH];
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              busy_ff, busy_in;
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] addr;

   assign addr       = req.addr[ADDR_W-1:0];
   assign rd_data    = rd_data_ff;
   assign clear_busy = busy_ff;

   // Clear sweep control
   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (req.wr_en) begin
         mem[addr] <= req.wdata;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

endmodule

@@ rtl/core/lcd_controller_bus_interface.sv @@
`timescale 1ns / 1ps

// Bus interface of a page/column LCD controller.
// req channel: one bus access per transfer. tuser[0] = func (1 write, 0 read),
// tuser[1] = port_select (1 display data, 0 command/status), tdata = byte.
// rsp channel: one result per access with the read byte (0 for writes) and
// the display settings after the access.
// Timing: a status read, any write and a data read that returns the dummy
// byte or hits an unmapped address load their result straight into the
// output register. A data read from the display RAM passes the RAM read
// register first (state ST_READ), then the output register.
// Throughput: one access per cycle while no result is stalled; a RAM read
// holds req_tready low in ST_READ, so the next access waits for its data.
// Reset: all settings return to their defaults and the display RAM is
// zeroed by a sweep over all RAM_COLUMNS * RAM_PAGES addresses (1188 by default);
// req_tready stays low until it ends.
// Stall: the result waits in the output register while rsp_tready is low;
// a new access is taken in the cycle the held result leaves.
module lcd_controller_bus_interface
   import lcdbi_pkg::*;
#(
   parameter int RAM_COLUMNS = DEF_RAM_COLUMNS,
   parameter int RAM_PAGES   = DEF_RAM_PAGES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,  // write_data
   input  logic [1:0]       req_tuser,  // func, port_select
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // read_data, min_intensity, max_intensity, display_enabled, first_row,
   // rows_flipped, columns_flipped, pixels_inverted, pixels_forced_on, pad
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int RAM_DEPTH = RAM_COLUMNS * RAM_PAGES;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam logic [7:0]       COLS_L   = 8'(RAM_COLUMNS);
   localparam logic [7:0]       LAST_COL = 8'(RAM_COLUMNS - 1);
   localparam logic [4:0]       PAGES_L  = 5'(RAM_PAGES);
   localparam logic [IDX_W-1:0] COLS_W   = IDX_W'(RAM_COLUMNS);
   localparam levels_type       LEVELS_RESET = map_contrast(CONTRAST_RESET);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   typedef struct packed {
      logic all_on;
      logic invert;
      logic row_rev;
      logic col_rev;
      logic disp_on;
   } mode_type;

   state_type    state_ff, state_in;
   logic [3:0]   page_ff, page_in;
   logic [7:0]   col_ff, col_in;
   logic [7:0]   saved_col_ff, saved_col_in;
   logic [5:0]   contrast_ff, contrast_in;
   logic         contrast_pend_ff, contrast_pend_in;
   levels_type   levels_ff, levels_in;
   logic         dummy_ff, dummy_in;
   logic         rmw_ff, rmw_in;
   mode_type     mode_ff, mode_in;
   logic [5:0]   line_ff, line_in;
   logic         rd_mask_ff, rd_mask_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   dram_req_type dram_req;
   logic [7:0]   ram_q;
   logic         clear_busy;

   logic         accept;
   logic         is_write;
   logic         is_data;
   logic [7:0]   byte_in;
   logic         addr_ok;
   logic [7:0]   col_eff;
   logic [IDX_W-1:0] ram_idx;

   assign is_write = req_tuser[0];
   assign is_data  = req_tuser[1];
   assign byte_in  = req_tdata;

   assign req_tready = !clear_busy && (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // Address of the current page/column, with column reverse
   assign addr_ok = (col_ff < COLS_L) && ({1'b0, page_ff} < PAGES_L);
   assign col_eff = mode_ff.col_rev ? (LAST_COL - col_ff) : col_ff;
   assign ram_idx = {8'b0, page_ff} * COLS_W + {4'b0, col_eff};

   lcdbi_dram #(
      .DEPTH  (RAM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_dram (
      .clock      (clock),
      .reset      (reset),
      .req        (dram_req),
      .rd_data    (ram_q),
      .clear_busy (clear_busy)
   );

   // Access decode and state update
   always_comb begin
      logic [7:0] rd;
      logic       to_read;
      rd               = 8'h00;
      to_read          = 1'b0;
      state_in         = state_ff;
      page_in          = page_ff;
      col_in           = col_ff;
      saved_col_in     = saved_col_ff;
      contrast_in      = contrast_ff;
      contrast_pend_in = contrast_pend_ff;
      levels_in        = levels_ff;
      dummy_in         = dummy_ff;
      rmw_in           = rmw_ff;
      mode_in          = mode_ff;
      line_in          = line_ff;
      rd_mask_in       = rd_mask_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_in           = rsp_ff;
      dram_req.rd_en   = 1'b0;
      dram_req.wr_en   = 1'b0;
      dram_req.addr    = ram_idx;
      dram_req.wdata   = byte_in;

      if (state_ff == ST_READ) begin
         // RAM data is back
         rd       = rd_mask_ff ? {7'b0, ram_q[0]} : ram_q;
         state_in = ST_IDLE;
      end else if (accept) begin
         if (is_write) begin
            if (contrast_pend_ff) begin
               contrast_pend_in = 1'b0;
               contrast_in      = byte_in[5:0];
               levels_in        = map_contrast(byte_in[5:0]);
            end else if (is_data) begin
               if (addr_ok) begin
                  dram_req.wr_en = 1'b1;
                  if (col_ff < LAST_COL) col_in = col_ff + 8'd1;
                  dummy_in = 1'b1;
               end
            end else begin
               priority if (byte_in <= CMD_COL_LO_MAX) begin
                  if (!rmw_ff) begin
                     col_in   = {col_ff[7:4], byte_in[3:0]};
                     dummy_in = 1'b1;
                  end
               end else if (byte_in <= CMD_COL_HI_MAX) begin
                  if (!rmw_ff) begin
                     col_in   = {byte_in[3:0], col_ff[3:0]};
                     dummy_in = 1'b1;
                  end
               end else if (byte_in >= CMD_LINE_MIN && byte_in <= CMD_LINE_MAX) begin
                  line_in = byte_in[5:0];
               end else if (byte_in >= CMD_PAGE_MIN && byte_in <= CMD_PAGE_MAX) begin
                  page_in = byte_in[3:0];
               end else if (byte_in >= CMD_ROWN_MIN && byte_in <= CMD_ROWN_MAX) begin
                  mode_in.row_rev = 1'b0;
               end else if (byte_in >= CMD_ROWR_MIN && byte_in <= CMD_ROWR_MAX) begin
                  mode_in.row_rev = 1'b1;
               end else begin
                  unique case (byte_in)
                     CMD_CONTRAST:     contrast_pend_in = 1'b1;
                     CMD_COL_NORMAL:   mode_in.col_rev  = 1'b0;
                     CMD_COL_REVERSE:  mode_in.col_rev  = 1'b1;
                     CMD_LEVEL_NORMAL: levels_in = map_contrast(contrast_ff);
                     CMD_LEVEL_MAX:    levels_in = map_contrast(CONTRAST_MAX);
                     CMD_ALLON_OFF:    mode_in.all_on  = 1'b0;
                     CMD_ALLON_ON:     mode_in.all_on  = 1'b1;
                     CMD_INVERT_OFF:   mode_in.invert  = 1'b0;
                     CMD_INVERT_ON:    mode_in.invert  = 1'b1;
                     CMD_DISPLAY_OFF:  mode_in.disp_on = 1'b0;
                     CMD_DISPLAY_ON:   mode_in.disp_on = 1'b1;
                     CMD_RMW_START: begin
                        rmw_in       = 1'b1;
                        saved_col_in = col_ff;
                     end
                     CMD_SOFT_RESET: begin
                        page_in          = '0;
                        col_in           = '0;
                        saved_col_in     = '0;
                        contrast_in      = CONTRAST_RESET;
                        contrast_pend_in = 1'b0;
                        levels_in        = LEVELS_RESET;
                        dummy_in         = 1'b1;
                        rmw_in           = 1'b0;
                        mode_in          = '0;
                        line_in          = '0;
                     end
                     CMD_RMW_END: begin
                        rmw_in = 1'b0;
                        col_in = saved_col_ff;
                     end
                     default: ;
                  endcase
               end
            end
         end else if (is_data) begin
            // Data read: dummy byte first, unmapped reads 0
            if (dummy_ff) begin
               dummy_in = 1'b0;
            end else if (addr_ok) begin
               dram_req.rd_en = 1'b1;
               rd_mask_in     = (page_ff >= PAGE_BIT0_ONLY);
               to_read        = 1'b1;
               state_in       = ST_READ;
               if (!rmw_ff) begin
                  if (col_ff < LAST_COL) col_in = col_ff + 8'd1;
                  dummy_in = 1'b1;
               end
            end
         end else begin
            rd = STATUS_BASE | (mode_ff.disp_on ? STATUS_ON : 8'h00);
         end
      end

      // Load the result register
      if ((state_ff == ST_READ) || (accept && !to_read)) begin
         rsp_valid_in            = 1'b1;
         rsp_in.pad              = '0;
         rsp_in.read_data        = rd;
         rsp_in.min_intensity    = levels_in.low;
         rsp_in.max_intensity    = levels_in.high;
         rsp_in.display_enabled  = mode_in.disp_on;
         rsp_in.first_row        = line_in;
         rsp_in.rows_flipped     = mode_in.row_rev;
         rsp_in.columns_flipped  = mode_in.col_rev;
         rsp_in.pixels_inverted  = mode_in.invert;
         rsp_in.pixels_forced_on = mode_in.all_on;
      end
   end

   // Control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         page_ff          <= '0;
         col_ff           <= '0;
         saved_col_ff     <= '0;
         contrast_ff      <= CONTRAST_RESET;
         contrast_pend_ff <= 1'b0;
         levels_ff        <= LEVELS_RESET;
         dummy_ff         <= 1'b0;
         rmw_ff           <= 1'b0;
         mode_ff          <= '0;
         line_ff          <= '0;
         rd_mask_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rsp_ff           <= '0;
      end else begin
         state_ff         <= state_in;
         page_ff          <= page_in;
         col_ff           <= col_in;
         saved_col_ff     <= saved_col_in;
         contrast_ff      <= contrast_in;
         contrast_pend_ff <= contrast_pend_in;
         levels_ff        <= levels_in;
         dummy_ff         <= dummy_in;
         rmw_ff           <= rmw_in;
         mode_ff          <= mode_in;
         line_ff          <= line_in;
         rd_mask_ff       <= rd_mask_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_ff           <= rsp_in;
      end
   end

endmodule

@@ rtl/core/lcdbi_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks on the LCD bus interface
module lcdbi_checker
   import lcdbi_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [1:0]       req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // A held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No new access while a result is stuck in the output register
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("access taken over a stalled result");

   // Every write answers next cycle with zero read data
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0]
      |=> rsp_tvalid && (rsp_tdata[7:0] == 8'h00))
      else $error("write transfer returned nonzero data");

   // Status read answers next cycle and mirrors the display-on flag
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] && !req_tuser[1]
      |=> rsp_tvalid
          && (rsp_tdata[7:0] == (STATUS_BASE | (rsp_tdata[24] ? STATUS_ON : 8'h00))))
      else $error("bad status byte");

endmodule

bind lcd_controller_bus_interface lcdbi_checker u_lcdbi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
